// ----- hdl/cbe_pkg.sv -----
// Shared types, field widths and register codes of the coordinate block expander.
package cbe_pkg;

   localparam int NODES_DEF   = 1024;
   localparam int MAX_DOF_DEF = 16;

   localparam int IDX_W      = 15;
   localparam int NODE_IN_W  = 11;
   localparam int VAL_W      = 64;
   localparam int DOF_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   localparam logic OP_TABLE = 1'b0;
   localparam logic OP_VALUE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_VARIABLE_DOFS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTANT_DOF   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BASE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMMETRIC_MODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_MAJOR   = 3'd4;

   typedef struct packed {
      logic                 operation;
      logic [NODE_IN_W-1:0] table_index;
      logic [IDX_W-1:0]     table_value;
      logic [NODE_IN_W-1:0] block_row;
      logic [NODE_IN_W-1:0] block_col;
      logic [VAL_W-1:0]     value_re;
      logic [VAL_W-1:0]     value_im;
   } cbe_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
      logic [VAL_W-1:0] out_value_re;
      logic [VAL_W-1:0] out_value_im;
      logic             block_last;
   } cbe_rsp_type;

   typedef struct packed {
      logic             variable_dofs;
      logic [DOF_W-1:0] constant_dof;
      logic             index_base;
      logic             symmetric_mode;
      logic             column_major;
   } cbe_cfg_type;

endpackage

// ----- hdl/cbe_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module cbe_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 1025
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                        rd_data_a,
   output logic [WIDTH-1:0]                        rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- hdl/cbe_walk.sv -----
// Block walk stage: block sizes, within-block counters, index add and result register.
module cbe_walk #(
   parameter int NODES   = cbe_pkg::NODES_DEF,
   parameter int MAX_DOF = cbe_pkg::MAX_DOF_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cbe_pkg::cbe_cfg_type                  cfg,
   input  logic                                  load,
   input  logic [$clog2(NODES+1)-1:0]            ld_row_node,
   input  logic [$clog2(NODES+1)-1:0]            ld_col_node,
   input  logic [cbe_pkg::IDX_W-1:0]             ld_row_cstart,
   input  logic [cbe_pkg::IDX_W-1:0]             ld_col_cstart,
   input  logic [cbe_pkg::VAL_W-1:0]             ld_value_re,
   input  logic [cbe_pkg::VAL_W-1:0]             ld_value_im,
   input  logic [cbe_pkg::IDX_W-1:0]             row_lo,
   input  logic [cbe_pkg::IDX_W-1:0]             row_hi,
   input  logic [cbe_pkg::IDX_W-1:0]             col_lo,
   input  logic [cbe_pkg::IDX_W-1:0]             col_hi,
   output logic                                  ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cbe_pkg::cbe_rsp_type                  rsp_payload
);
   import cbe_pkg::*;

   localparam int AW = $clog2(NODES + 1);
   localparam int CW = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;
   localparam int SW = $clog2(MAX_DOF + 1);

   function automatic logic [SW-1:0] block_size(
      input logic             variable,
      input logic [IDX_W-1:0] lo,
      input logic [IDX_W-1:0] hi,
      input logic [DOF_W-1:0] cdof
   );
      logic signed [IDX_W:0] diff;
      logic [SW-1:0]         size;
      diff = signed'({1'b0, hi}) - signed'({1'b0, lo});
      if (variable) begin
         if (diff < 1) begin
            size = SW'(1);
         end else if (int'(diff) > MAX_DOF) begin
            size = SW'(MAX_DOF);
         end else begin
            size = SW'(diff);
         end
      end else begin
         if (cdof == '0) begin
            size = SW'(1);
         end else if (int'(cdof) > MAX_DOF) begin
            size = SW'(MAX_DOF);
         end else begin
            size = SW'(cdof);
         end
      end
      return size;
   endfunction

   logic             s1_valid_ff, s1_valid_in;
   logic [AW-1:0]    s1_row_node_ff, s1_col_node_ff;
   logic [IDX_W-1:0] s1_row_cstart_ff, s1_col_cstart_ff;
   logic [VAL_W-1:0] s1_value_re_ff, s1_value_im_ff;
   logic [CW-1:0]    inner_ff, inner_in;
   logic [CW-1:0]    outer_ff, outer_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cbe_rsp_type      rsp_ff;

   logic [SW-1:0]    dofi, dofj, isz, osz;
   logic [IDX_W-1:0] rs, cs;
   logic [CW-1:0]    ii, jj;
   logic             keep, inner_wrap, outer_wrap;
   logic             out_take, s1_done, out_load;

   always_comb begin
      dofi = block_size(cfg.variable_dofs, row_lo, row_hi, cfg.constant_dof);
      dofj = block_size(cfg.variable_dofs, col_lo, col_hi, cfg.constant_dof);
      rs   = cfg.variable_dofs ? row_lo : s1_row_cstart_ff;
      cs   = cfg.variable_dofs ? col_lo : s1_col_cstart_ff;
      if (cfg.column_major) begin
         ii  = inner_ff;
         jj  = outer_ff;
         isz = dofi;
         osz = dofj;
      end else begin
         ii  = outer_ff;
         jj  = inner_ff;
         isz = dofj;
         osz = dofi;
      end
      keep       = !(cfg.symmetric_mode && (s1_row_node_ff == s1_col_node_ff) && (ii < jj));
      inner_wrap = (int'(inner_ff) + 1) >= int'(isz);
      outer_wrap = (int'(outer_ff) + 1) >= int'(osz);

      out_take = !rsp_valid_ff || !rsp_stall;
      s1_done  = s1_valid_ff && (!keep || out_take);
      out_load = s1_valid_ff && keep && out_take;
      ready    = !s1_valid_ff || s1_done;

      s1_valid_in = load ? 1'b1 : (s1_valid_ff && !s1_done);

      inner_in = inner_ff;
      outer_in = outer_ff;
      if (s1_done) begin
         if (inner_wrap) begin
            inner_in = '0;
            outer_in = outer_wrap ? '0 : CW'(outer_ff + 1'b1);
         end else begin
            inner_in = CW'(inner_ff + 1'b1);
         end
      end

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         inner_ff     <= '0;
         outer_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         inner_ff     <= inner_in;
         outer_ff     <= outer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_row_node_ff   <= ld_row_node;
         s1_col_node_ff   <= ld_col_node;
         s1_row_cstart_ff <= ld_row_cstart;
         s1_col_cstart_ff <= ld_col_cstart;
         s1_value_re_ff   <= ld_value_re;
         s1_value_im_ff   <= ld_value_im;
      end
      if (out_load) begin
         rsp_ff.out_row      <= IDX_W'(rs + IDX_W'(ii));
         rsp_ff.out_col      <= IDX_W'(cs + IDX_W'(jj));
         rsp_ff.out_value_re <= s1_value_re_ff;
         rsp_ff.out_value_im <= s1_value_im_ff;
         rsp_ff.block_last   <= inner_wrap && outer_wrap;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- hdl/coordinate_block_expander.sv -----
// Coordinate block expander top level: registers, node decode, offset tables, block walk.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  cbe_req_type
//   rsp      out        rsp_valid / rsp_stall  cbe_rsp_type
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One item per cycle sustained while rsp_stall is low. The transfer edge of a value reads the
// offset table and loads the walk stage; the result register then takes the value once it is not
// stalled. In symmetric mode, a diagonal-block entry with row offset below column offset gives no result.
// Table writes finish at their transfer and give no result.
// Synchronous reset sets config defaults and clears counters and valids; data regs and offset table are not cleared.
// rsp_stall holds the result register; req_stall rises only when the walk stage is still full.
module coordinate_block_expander #(
   parameter int NODES   = cbe_pkg::NODES_DEF,
   parameter int MAX_DOF = cbe_pkg::MAX_DOF_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cbe_pkg::cbe_req_type               req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cbe_pkg::cbe_rsp_type               rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import cbe_pkg::*;

   localparam int AW = $clog2(NODES + 1);
   localparam int PW = DOF_W + AW;

   function automatic logic [AW-1:0] node_sat(input logic [NODE_IN_W-1:0] n);
      logic [AW-1:0] node;
      if (int'(n) >= NODES) begin
         node = AW'(NODES - 1);
      end else begin
         node = AW'(n);
      end
      return node;
   endfunction

   cbe_cfg_type cfg_ff, cfg_in;

   logic                 walk_ready, req_fire, is_value, tbl_wr;
   logic [NODE_IN_W-1:0] raw_row, raw_col;
   logic [AW-1:0]        ni, nj;
   logic [PW-1:0]        prod_row, prod_col;
   logic [IDX_W-1:0]     cstart_row, cstart_col;
   logic [IDX_W-1:0]     row_lo, row_hi, col_lo, col_hi;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VARIABLE_DOFS:  cfg_in.variable_dofs  = csr_data[0];
            CSR_CONSTANT_DOF:   cfg_in.constant_dof   = csr_data[DOF_W-1:0];
            CSR_INDEX_BASE:     cfg_in.index_base     = csr_data[0];
            CSR_SYMMETRIC_MODE: cfg_in.symmetric_mode = csr_data[0];
            CSR_COLUMN_MAJOR:   cfg_in.column_major   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.variable_dofs  <= 1'b0;
         cfg_ff.constant_dof   <= DOF_W'(1);
         cfg_ff.index_base     <= 1'b0;
         cfg_ff.symmetric_mode <= 1'b0;
         cfg_ff.column_major   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_stall = !walk_ready;
      req_fire  = req_valid && !req_stall;
      is_value  = req_payload.operation == OP_VALUE;
      tbl_wr    = req_fire && !is_value && (int'(req_payload.table_index) <= NODES);

      raw_row = req_payload.block_row - NODE_IN_W'(cfg_ff.index_base);
      raw_col = req_payload.block_col - NODE_IN_W'(cfg_ff.index_base);
      ni      = node_sat(raw_row);
      nj      = node_sat(raw_col);

      prod_row   = PW'(cfg_ff.constant_dof) * PW'(ni);
      prod_col   = PW'(cfg_ff.constant_dof) * PW'(nj);
      cstart_row = IDX_W'(prod_row + PW'(cfg_ff.index_base));
      cstart_col = IDX_W'(prod_col + PW'(cfg_ff.index_base));
   end

   // Table kept twice so row and column lookups each get two read ports.
   cbe_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NODES + 1)
   ) u_row_table (
      .clock     (clock),
      .wr_en     (tbl_wr),
      .wr_addr   (AW'(req_payload.table_index)),
      .wr_data   (req_payload.table_value),
      .rd_en     (req_fire && is_value),
      .rd_addr_a (ni),
      .rd_addr_b (AW'(ni + 1'b1)),
      .rd_data_a (row_lo),
      .rd_data_b (row_hi)
   );

   cbe_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NODES + 1)
   ) u_col_table (
      .clock     (clock),
      .wr_en     (tbl_wr),
      .wr_addr   (AW'(req_payload.table_index)),
      .wr_data   (req_payload.table_value),
      .rd_en     (req_fire && is_value),
      .rd_addr_a (nj),
      .rd_addr_b (AW'(nj + 1'b1)),
      .rd_data_a (col_lo),
      .rd_data_b (col_hi)
   );

   cbe_walk #(
      .NODES   (NODES),
      .MAX_DOF (MAX_DOF)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .load          (req_fire && is_value),
      .ld_row_node   (ni),
      .ld_col_node   (nj),
      .ld_row_cstart (cstart_row),
      .ld_col_cstart (cstart_col),
      .ld_value_re   (req_payload.value_re),
      .ld_value_im   (req_payload.value_im),
      .row_lo        (row_lo),
      .row_hi        (row_hi),
      .col_lo        (col_lo),
      .col_hi        (col_hi),
      .ready         (walk_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule
